// File: hw/rtl/snr_pkg.sv
// ----------------------------------------------------------------------------
// snr_pkg: shared constants and types for the SNR meter
// Status codes, log and dB scaling constants, and the front/back queue entry.
// ----------------------------------------------------------------------------
package snr_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int RUN_LENGTH_LOG2_DEF = 16;

    localparam int LOG_FRAC_BITS = 20;
    localparam int DB_K          = 197283;
    localparam int DB_SHIFT      = 28;
    localparam int DB_MAG_CAP    = 40000;

    localparam logic [1:0] ST_NORMAL     = 2'd0;
    localparam logic [1:0] ST_NOISE_ZERO = 2'd1;
    localparam logic [1:0] ST_SIG_ZERO   = 2'd2;

    localparam logic signed [15:0] DB_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DB_MIN = -16'sh8000;

    // One closed run handed from the accumulator to the log unit.
    typedef struct packed {
        logic [63:0] sig_e;
        logic [63:0] noise_e;
    } snr_run_t;

endpackage

// File: hw/rtl/snr_accum.sv
// ----------------------------------------------------------------------------
// snr_accum: front end of the SNR meter
// Takes one sample pair per cycle while the two-entry queue is not full,
// squares, accumulates with saturation, queues the closed run on the last pair.
// ----------------------------------------------------------------------------
module snr_accum #(
    parameter int SAMPLE_BITS     = snr_pkg::SAMPLE_BITS_DEF,
    parameter int RUN_LENGTH_LOG2 = snr_pkg::RUN_LENGTH_LOG2_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_clean_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_noisy_sample,
    input  logic                          s_last_sample,
    output logic                          q_valid,
    input  logic                          q_ready,
    output snr_pkg::snr_run_t             q_data
);
    localparam int SW = 2 * SAMPLE_BITS + RUN_LENGTH_LOG2;
    localparam int NW = 2 * (SAMPLE_BITS + 1) + RUN_LENGTH_LOG2;
    localparam int SWC = (SW > 64) ? 64 : SW;
    localparam int NWC = (NW > 64) ? 64 : NW;
    localparam int PW  = 2 * (SAMPLE_BITS + 1);

    logic [SWC-1:0] sig_reg, sig_next;
    logic [NWC-1:0] noise_reg, noise_next;
    snr_pkg::snr_run_t q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        ca, da;
    logic [PW-1:0]               csq, dsq;
    logic [SWC:0]                sig_sum;
    logic [NWC:0]                noise_sum;
    logic                        push, pop;

    // Absolute values and squares of the reference and the noise.
    always_comb begin
        diff = {s_noisy_sample[SAMPLE_BITS-1], s_noisy_sample}
             - {s_clean_sample[SAMPLE_BITS-1], s_clean_sample};
        ca = s_clean_sample[SAMPLE_BITS-1]
           ? (SAMPLE_BITS+1)'(-{s_clean_sample[SAMPLE_BITS-1], s_clean_sample})
           : {1'b0, s_clean_sample};
        da = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;
        csq = PW'(ca * ca);
        dsq = PW'(da * da);
        sig_sum   = {1'b0, sig_reg} + (SWC+1)'(csq);
        noise_sum = {1'b0, noise_reg} + (NWC+1)'(dsq);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && s_last_sample;
    assign pop     = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_mem[rd_ptr_reg];

    // Saturating accumulation; the sums clear after the last pair.
    always_comb begin
        sig_next   = sig_sum[SWC] ? '1 : sig_sum[SWC-1:0];
        noise_next = noise_sum[NWC] ? '1 : noise_sum[NWC-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg    <= '0;
            noise_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                sig_reg   <= s_last_sample ? '0 : sig_next;
                noise_reg <= s_last_sample ? '0 : noise_next;
            end
            if (push) begin
                q_mem[wr_ptr_reg] <= '{sig_e: 64'(sig_next), noise_e: 64'(noise_next)};
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: hw/rtl/snr_log.sv
// ----------------------------------------------------------------------------
// snr_log: back end of the SNR meter
// Sequencer with one shared squaring unit: leading-one search, normalize,
// 20 fraction squarings per energy, then dB scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module snr_log (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  snr_pkg::snr_run_t        q_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [15:0]       m_snr_db,
    output logic [1:0]               m_status
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg;
    logic [63:0] sig_reg, noise_reg;
    logic        which_reg;          // 0: signal, 1: noise
    logic [5:0]  exp_reg;
    logic [32:0] m_reg;
    logic [4:0]  it_reg;
    logic [25:0] ls_reg, ln_reg;
    logic [27:0] dmag_reg;
    logic        neg_reg;
    logic [45:0] prod_reg;
    logic signed [15:0] db_reg;
    logic [1:0]  st_reg;

    logic [63:0] x;
    logic [5:0]  lead;
    logic [63:0] mq;
    logic [65:0] sq;
    logic [32:0] msq;
    logic [26:0] ldiff;
    logic [46:0] rnd;
    logic [18:0] mag;

    assign x = which_reg ? noise_reg : sig_reg;

    // Leading-one position of the current energy.
    always_comb begin
        lead = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) lead = 6'(i);
        end
        if (lead > 6'd31) mq = x >> (lead - 6'd31);
        else              mq = x << (6'd31 - lead);
    end

    // One squaring step of the fraction loop.
    always_comb begin
        sq  = 66'(m_reg) * 66'(m_reg);
        msq = 33'(sq >> 31);
    end

    always_comb begin
        ldiff = {1'b0, ls_reg} - {1'b0, ln_reg};
        rnd   = {1'b0, prod_reg} + (47'(1) << (snr_pkg::DB_SHIFT - 1));
        mag   = 19'(rnd >> snr_pkg::DB_SHIFT);
    end

    assign q_ready  = (state_reg == S_IDLE);
    assign m_valid  = (state_reg == S_OUT);
    assign m_snr_db = db_reg;
    assign m_status = st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        sig_reg   <= q_data.sig_e;
                        noise_reg <= q_data.noise_e;
                        which_reg <= 1'b0;
                        if (q_data.noise_e == '0) begin
                            db_reg    <= snr_pkg::DB_MAX;
                            st_reg    <= snr_pkg::ST_NOISE_ZERO;
                            state_reg <= S_OUT;
                        end else if (q_data.sig_e == '0) begin
                            db_reg    <= snr_pkg::DB_MIN;
                            st_reg    <= snr_pkg::ST_SIG_ZERO;
                            state_reg <= S_OUT;
                        end else begin
                            st_reg    <= snr_pkg::ST_NORMAL;
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    exp_reg   <= lead;
                    m_reg     <= mq[32:0];
                    it_reg    <= '0;
                    state_reg <= S_SQR;
                end
                S_SQR: begin
                    // Fraction bits collect in the low part of the log word.
                    if (msq[32]) m_reg <= msq >> 1;
                    else         m_reg <= msq;
                    if (!which_reg) ls_reg <= {exp_reg, (ls_reg[18:0]), msq[32]};
                    else            ln_reg <= {exp_reg, (ln_reg[18:0]), msq[32]};
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'(snr_pkg::LOG_FRAC_BITS - 1)) begin
                        if (!which_reg) begin
                            which_reg <= 1'b1;
                            state_reg <= S_NORM;
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    neg_reg   <= ldiff[26];
                    dmag_reg  <= ldiff[26] ? 28'(-{ldiff[26], ldiff}) : 28'(ldiff);
                    state_reg <= S_RND;
                    prod_reg  <= '0;
                end
                S_RND: begin
                    if (prod_reg == '0 && dmag_reg != '0) begin
                        prod_reg <= 46'(dmag_reg) * 46'(snr_pkg::DB_K);
                    end else begin
                        if (neg_reg)
                            db_reg <= (mag >= 19'd32768) ? snr_pkg::DB_MIN : 16'(-mag);
                        else
                            db_reg <= (mag >= 19'd32767) ? snr_pkg::DB_MAX : 16'(mag);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/snr_meter.sv
// ----------------------------------------------------------------------------
// snr_meter: signal-to-noise ratio meter in dB
// Accumulates reference and noise energy over a run and reports Q7.8 dB.
// ----------------------------------------------------------------------------
//  channel   ports                                         direction
//  s_        s_valid s_ready s_clean_sample s_noisy_sample s_last_sample  in
//  m_        m_valid m_ready m_snr_db m_status                            out
//
// Sample pairs are taken one per cycle while the queue is not full; the
// accumulator is the only loop in the front end. A closed run enters a two-entry
// queue; each run holds the log unit for two normalizations, 40 squarings,
// multiply and round with m_ready high, with no multiply at exactly 0 dB and
// none of these when an energy is zero. Shorter runs stall the input once the
// queue is full, and a low m_ready stalls the log unit. Reset clears both sums.
module snr_meter #(
    parameter int SAMPLE_BITS     = snr_pkg::SAMPLE_BITS_DEF,
    parameter int RUN_LENGTH_LOG2 = snr_pkg::RUN_LENGTH_LOG2_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_clean_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_noisy_sample,
    input  logic                          s_last_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_snr_db,
    output logic [1:0]                    m_status
);
    logic              q_valid, q_ready;
    snr_pkg::snr_run_t q_data;

    snr_accum #(.SAMPLE_BITS(SAMPLE_BITS), .RUN_LENGTH_LOG2(RUN_LENGTH_LOG2)) u_accum (
        .aclk, .aresetn, .s_valid, .s_ready, .s_clean_sample, .s_noisy_sample,
        .s_last_sample, .q_valid, .q_ready, .q_data
    );

    snr_log u_log (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_snr_db, .m_status
    );
endmodule
